// ===== rtl/mrt_pkg.sv =====
// Package for the masked route table: status codes, default depth and the
// token that travels the cell chain. No dependencies.
package mrt_pkg;

    localparam int MRT_TABLE_DEPTH = 16;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_NO_IFACE = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } status_t;

    // One beat in flight along the chain. For a lookup, gw and iface carry
    // the winning route once hit is set; for an add they carry the new route.
    typedef struct packed {
        logic        valid;
        logic        lookup;
        logic        write;
        logic        hit;
        status_t     status;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [7:0]  iface;
    } mrt_token_t;

endpackage

// ===== rtl/mrt_req_if.sv =====
// Request channel of the masked route table: valid/ready plus the input beat.
// No dependencies.
interface mrt_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] address;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [7:0]  route_iface;

    modport source (output valid, func, address, route_mask, route_gateway, route_iface,
                    input ready);
    modport sink   (input valid, func, address, route_mask, route_gateway, route_iface,
                    output ready);
endinterface

// ===== rtl/mrt_rsp_if.sv =====
// Response channel of the masked route table: valid/ready plus the result beat.
// No dependencies.
interface mrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  out_iface;
    logic [31:0] out_gateway;

    modport source (output valid, status, out_iface, out_gateway, input ready);
    modport sink   (input valid, status, out_iface, out_gateway, output ready);
endinterface

// ===== rtl/mrt_cell.sv =====
// One route table cell: holds a single entry and passes the token on.
// Depends on mrt_pkg.
module mrt_cell #(
    parameter int TABLE_DEPTH = mrt_pkg::MRT_TABLE_DEPTH,
    parameter int INDEX       = 0,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic [CNT_W-1:0]    count,
    input  mrt_pkg::mrt_token_t tok_in,
    output mrt_pkg::mrt_token_t tok_out
);
    import mrt_pkg::*;

    logic [31:0] dest_reg;
    logic [31:0] mask_reg;
    logic [31:0] gw_reg;
    logic [7:0]  iface_reg;
    mrt_token_t  tok_reg;
    mrt_token_t  tok_next;
    logic        occupied;
    logic        match;
    logic        write_en;

    always_comb
    begin
        occupied = CNT_W'(INDEX) < count;
        match    = (tok_in.addr & mask_reg) == dest_reg;
        tok_next = tok_in;
        // the first cell that matches wins; later cells see hit set
        if (tok_in.valid && tok_in.lookup && !tok_in.hit && occupied && match)
        begin
            tok_next.hit    = 1'b1;
            tok_next.status = ST_HIT;
            tok_next.gw     = gw_reg;
            tok_next.iface  = iface_reg;
        end
    end

    // count is bumped only when the beat leaves the chain, so the new route
    // lands at index count
    assign write_en = shift_en && tok_in.valid && tok_in.write
                      && (CNT_W'(INDEX) == count);

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            dest_reg  <= tok_in.addr;
            mask_reg  <= tok_in.mask;
            gw_reg    <= tok_in.gw;
            iface_reg <= tok_in.iface;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (shift_en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/masked_route_table_unit.sv =====
// Masked route table, top level: entry logic, cell chain and result register.
// Depends on mrt_pkg, mrt_req_if, mrt_rsp_if and mrt_cell.
//
//  channel | dir | beat
//  --------+-----+--------------------------------------------------------
//  req     | in  | func, address, route_mask, route_gateway, route_iface
//  rsp     | out | status, out_iface, out_gateway
//
// One beat at a time: a beat walks the chain one cell per cycle unless the
// chain holds, then enters the output register; the next beat is taken the
// cycle after that. A waiting result does not block it. Reset clears the
// route count and the control state; entries are not cleared. The whole chain
// holds if a beat waits at its end and a full output register is not taken.
module masked_route_table_unit #(
    parameter int TABLE_DEPTH = mrt_pkg::MRT_TABLE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    mrt_req_if.sink   req,
    mrt_rsp_if.source rsp
);
    import mrt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;
    logic [2:0]         status_reg;
    logic [7:0]         iface_reg;
    logic [31:0]        gw_reg;

    mrt_token_t         tok [TABLE_DEPTH+1];
    mrt_token_t         tail;
    logic               accept;
    logic               full;
    logic               take_ok;
    logic               shift_en;
    logic               load;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        tok[0]        = '0;
        tok[0].valid  = accept;
        tok[0].lookup = req.func;
        tok[0].addr   = req.address;
        tok[0].mask   = req.route_mask;
        if (req.func)
        begin
            tok[0].status = ST_MISS;
        end
        else
        begin
            tok[0].gw    = req.route_gateway;
            tok[0].iface = req.route_iface;
            priority if (req.route_iface == 8'd0)
            begin
                tok[0].status = ST_NO_IFACE;
            end
            else if (full)
            begin
                tok[0].status = ST_FULL;
            end
            else
            begin
                tok[0].status = ST_ADDED;
                tok[0].write  = 1'b1;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            mrt_cell #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .INDEX       (i),
                .CNT_W       (CNT_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .count    (count_reg),
                .tok_in   (tok[i]),
                .tok_out  (tok[i+1])
            );
        end
    endgenerate

    assign tail     = tok[TABLE_DEPTH];
    assign take_ok  = !out_valid_reg || rsp.ready;
    assign shift_en = !tail.valid || take_ok;
    assign load     = tail.valid && take_ok;

    // the count moves once the add has left the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load && tail.write)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            iface_reg     <= '0;
            gw_reg        <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_BUSY;
                    end
                end
                S_BUSY:
                begin
                    if (load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= tail.status;
                // adds answer with zero route fields
                iface_reg     <= tail.lookup ? tail.iface : 8'd0;
                gw_reg        <= tail.lookup ? tail.gw : 32'd0;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_iface   = iface_reg;
    assign rsp.out_gateway = gw_reg;

endmodule

// ===== rtl/mrt_checker.sv =====
// Port-level checks for the masked route table, bound to the top level.
// Depends on mrt_pkg and masked_route_table_unit.
module mrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [7:0]  out_iface,
    input logic [31:0] out_gateway
);
    import mrt_pkg::*;

    // one beat in flight: after an accept the request side closes
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a beat is in flight");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_MISS))
        else $error("status code out of range");

    a_zero_on_nonhit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ST_HIT) |-> (out_iface == 8'd0 && out_gateway == 32'd0))
        else $error("route fields not zero on add or miss");

    // stored routes never have interface 0
    a_hit_has_iface: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_HIT) |-> (out_iface != 8'd0))
        else $error("hit on a route with no interface");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status)
                                       && $stable(out_iface) && $stable(out_gateway)))
        else $error("stalled response beat changed");

endmodule

bind masked_route_table_unit mrt_checker u_mrt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .out_iface   (rsp.out_iface),
    .out_gateway (rsp.out_gateway)
);
